FILE: rtl/bbp_pkg.sv
package bbp_pkg;

    localparam int SCALE_BITS = 24;
    localparam int TABLE_LEN  = 24;
    localparam int ANGLE_W    = 24;
    localparam int BEARING_W  = 15;
    localparam int FRAC_EXTRA = 8;

    localparam logic signed [ANGLE_W-1:0] DEG180 = 24'sd2949120;
    localparam logic signed [ANGLE_W-1:0] DEG360 = 24'sd5898240;
    localparam logic [ANGLE_W-1:0]        ROUND_HALF = 24'd128;
    localparam logic [BEARING_W:0]        FULL_TURN  = 16'd23040;
    localparam logic [BEARING_W-1:0]      HALF_TURN  = 15'd11520;
    localparam logic [BEARING_W-1:0]      ZERO_TURN  = 15'd0;

    typedef struct packed {
        logic valid;
        logic flat;       // dy is zero: bearing is fixed, CORDIC result ignored
        logic west;       // dx negative
        logic half_turn;  // vector was turned by 180 degrees
    } ctrl_t;

    // atan(2^-idx) in units of 2^-14 degree, rounded to nearest
    function automatic logic [ANGLE_W-1:0] step_angle(input int idx);
        logic [ANGLE_W-1:0] ang;
        case (idx)
            0:       ang = 24'd737280;
            1:       ang = 24'd435242;
            2:       ang = 24'd229970;
            3:       ang = 24'd116736;
            4:       ang = 24'd58595;
            5:       ang = 24'd29326;
            6:       ang = 24'd14667;
            7:       ang = 24'd7334;
            8:       ang = 24'd3667;
            9:       ang = 24'd1833;
            10:      ang = 24'd917;
            11:      ang = 24'd458;
            12:      ang = 24'd229;
            13:      ang = 24'd115;
            14:      ang = 24'd57;
            15:      ang = 24'd29;
            16:      ang = 24'd14;
            17:      ang = 24'd7;
            18:      ang = 24'd4;
            19:      ang = 24'd2;
            20:      ang = 24'd1;
            default: ang = 24'd0;
        endcase
        return ang;
    endfunction

endpackage

FILE: rtl/bearing_between_points.sv
// Bearing between two screen positions.
// Command channel: drive first_x, first_y, second_x, second_y and raise start;
// the transaction is taken at the rising edge where start is high and busy is
// low. busy stays low, so a new transaction can be issued every cycle.
// Result channel: done pulses for one cycle with bearing valid in that same
// cycle, in units of 1/64 degree (0..23039), measured as atan2(dy, -dx) with
// dx, dy = first minus second. Results leave in the order taken.
// The pipeline is a prep register that forms the difference and folds it into
// the right half-plane, a register stage per CORDIC vectoring step, and the
// finish registers that add the base angle, round and wrap.
// Throughput is one transaction per cycle, set by the fully unrolled CORDIC
// pipeline with one step per register stage.
// There is no result backpressure: done is never held off by the receiver.
// Reset clears all valid bits in the pipeline; no result appears until a
// transaction has been taken after reset.
module bearing_between_points #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COORD_WIDTH-1:0]    first_x,
    input  logic signed [COORD_WIDTH-1:0]    first_y,
    input  logic signed [COORD_WIDTH-1:0]    second_x,
    input  logic signed [COORD_WIDTH-1:0]    second_y,
    output logic                             done,
    output logic [bbp_pkg::BEARING_W-1:0]    bearing
);
    import bbp_pkg::*;

    localparam int DATA_W = COORD_WIDTH + 3 + SCALE_BITS;
    localparam int STEPS  = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    ctrl_t                     ctrl_pipe [STEPS+1];
    logic signed [DATA_W-1:0]  u_pipe    [STEPS+1];
    logic signed [DATA_W-1:0]  v_pipe    [STEPS+1];
    logic signed [ANGLE_W-1:0] z_pipe    [STEPS+1];
    logic                      accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    bbp_prep #(
        .COORD_WIDTH(COORD_WIDTH),
        .DATA_W     (DATA_W)
    ) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(accept),
        .first_x (first_x),
        .first_y (first_y),
        .second_x(second_x),
        .second_y(second_y),
        .ctrl_out(ctrl_pipe[0]),
        .u_out   (u_pipe[0]),
        .v_out   (v_pipe[0])
    );

    assign z_pipe[0] = '0;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        bbp_cordic_stage #(
            .STEP  (i),
            .DATA_W(DATA_W)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl_in (ctrl_pipe[i]),
            .u_in    (u_pipe[i]),
            .v_in    (v_pipe[i]),
            .z_in    (z_pipe[i]),
            .ctrl_out(ctrl_pipe[i+1]),
            .u_out   (u_pipe[i+1]),
            .v_out   (v_pipe[i+1]),
            .z_out   (z_pipe[i+1])
        );
    end

    bbp_finish u_finish (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl_in(ctrl_pipe[STEPS]),
        .z_in   (z_pipe[STEPS]),
        .done   (done),
        .bearing(bearing)
    );

endmodule

FILE: rtl/bbp_prep.sv
module bbp_prep #(
    parameter int COORD_WIDTH = 16,
    parameter int DATA_W      = 43
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    output bbp_pkg::ctrl_t                ctrl_out,
    output logic signed [DATA_W-1:0]      u_out,
    output logic signed [DATA_W-1:0]      v_out
);
    import bbp_pkg::*;

    localparam int MAG_W = COORD_WIDTH + 2;

    logic signed [MAG_W-1:0]  dx;
    logic signed [MAG_W-1:0]  dy;
    logic signed [MAG_W-1:0]  u_fold;
    logic signed [MAG_W-1:0]  v_fold;
    ctrl_t                    ctrl_reg;
    ctrl_t                    ctrl_next;
    logic signed [DATA_W-1:0] u_reg;
    logic signed [DATA_W-1:0] u_next;
    logic signed [DATA_W-1:0] v_reg;
    logic signed [DATA_W-1:0] v_next;

    always_comb
    begin
        dx = MAG_W'(first_x) - MAG_W'(second_x);
        dy = MAG_W'(first_y) - MAG_W'(second_y);
        ctrl_next.valid     = in_valid;
        ctrl_next.flat      = (dy == '0);
        ctrl_next.west      = dx[MAG_W-1];
        // u = -dx; turn into the right half-plane when u is negative
        ctrl_next.half_turn = (dx > 0);
        if (dx > 0)
        begin
            u_fold = dx;
            v_fold = -dy;
        end
        else
        begin
            u_fold = -dx;
            v_fold = dy;
        end
        u_next = {{(DATA_W-SCALE_BITS-MAG_W){u_fold[MAG_W-1]}}, u_fold, SCALE_BITS'(0)};
        v_next = {{(DATA_W-SCALE_BITS-MAG_W){v_fold[MAG_W-1]}}, v_fold, SCALE_BITS'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
    end

    assign ctrl_out = ctrl_reg;
    assign u_out    = u_reg;
    assign v_out    = v_reg;

endmodule

FILE: rtl/bbp_cordic_stage.sv
module bbp_cordic_stage #(
    parameter int STEP   = 0,
    parameter int DATA_W = 43
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bbp_pkg::ctrl_t                    ctrl_in,
    input  logic signed [DATA_W-1:0]          u_in,
    input  logic signed [DATA_W-1:0]          v_in,
    input  logic signed [bbp_pkg::ANGLE_W-1:0] z_in,
    output bbp_pkg::ctrl_t                    ctrl_out,
    output logic signed [DATA_W-1:0]          u_out,
    output logic signed [DATA_W-1:0]          v_out,
    output logic signed [bbp_pkg::ANGLE_W-1:0] z_out
);
    import bbp_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ANGLE = $signed(step_angle(STEP));

    logic signed [DATA_W-1:0]  us;
    logic signed [DATA_W-1:0]  vs;
    ctrl_t                     ctrl_reg;
    logic signed [DATA_W-1:0]  u_reg;
    logic signed [DATA_W-1:0]  u_next;
    logic signed [DATA_W-1:0]  v_reg;
    logic signed [DATA_W-1:0]  v_next;
    logic signed [ANGLE_W-1:0] z_reg;
    logic signed [ANGLE_W-1:0] z_next;

    always_comb
    begin
        us = u_in >>> STEP;
        vs = v_in >>> STEP;
        // rotate toward the x axis by the sign of v
        if (!v_in[DATA_W-1])
        begin
            u_next = u_in + vs;
            v_next = v_in - us;
            z_next = z_in + ANGLE;
        end
        else
        begin
            u_next = u_in - vs;
            v_next = v_in + us;
            z_next = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        z_reg <= z_next;
    end

    assign ctrl_out = ctrl_reg;
    assign u_out    = u_reg;
    assign v_out    = v_reg;
    assign z_out    = z_reg;

endmodule

FILE: rtl/bbp_finish.sv
module bbp_finish (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bbp_pkg::ctrl_t                     ctrl_in,
    input  logic signed [bbp_pkg::ANGLE_W-1:0] z_in,
    output logic                               done,
    output logic [bbp_pkg::BEARING_W-1:0]      bearing
);
    import bbp_pkg::*;

    localparam int RND_W = ANGLE_W - FRAC_EXTRA;

    logic signed [ANGLE_W-1:0] total;
    logic signed [ANGLE_W-1:0] folded;
    ctrl_t                     ctrl_reg;
    logic [ANGLE_W-2:0]        total_reg;
    logic [ANGLE_W-2:0]        total_next;
    logic [ANGLE_W-1:0]        rounded;
    logic [RND_W-1:0]          turns;
    logic                      done_reg;
    logic [BEARING_W-1:0]      bearing_reg;
    logic [BEARING_W-1:0]      bearing_next;

    // stage one: add base angle, fold into [0, 360)
    always_comb
    begin
        total = z_in + (ctrl_in.half_turn ? DEG180 : '0);
        if (total[ANGLE_W-1])
        begin
            folded = total + DEG360;
        end
        else
        begin
            folded = total;
        end
        total_next = folded[ANGLE_W-2:0];
    end

    // stage two: round half up to 1/64 degree, wrap 360 to 0; flat vectors take a fixed bearing
    always_comb
    begin
        rounded = {1'b0, total_reg} + ROUND_HALF;
        turns   = rounded[ANGLE_W-1:FRAC_EXTRA];
        if (ctrl_reg.flat)
        begin
            bearing_next = ctrl_reg.west ? ZERO_TURN : HALF_TURN;
        end
        else if (turns >= FULL_TURN)
        begin
            bearing_next = BEARING_W'(turns - FULL_TURN);
        end
        else
        begin
            bearing_next = BEARING_W'(turns);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
            done_reg <= ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        bearing_reg <= bearing_next;
    end

    assign done    = done_reg;
    assign bearing = bearing_reg;

endmodule

FILE: dv/tb_bearing_between_points.sv
`timescale 1ns / 100ps

module tb_bearing_between_points;

    import bbp_pkg::*;

    localparam int N_STEPS     = 16;
    localparam int CW          = 16;
    localparam int LATENCY     = N_STEPS + 3;
    localparam int N_DIRECTED  = 21;
    localparam int N_RANDOM    = 1700;

    typedef struct packed {
        logic signed [CW-1:0]  fx;
        logic signed [CW-1:0]  fy;
        logic signed [CW-1:0]  sx;
        logic signed [CW-1:0]  sy;
        logic                  known;
        logic [BEARING_W-1:0]  want;
    } probe_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic signed [CW-1:0]  first_x;
    logic signed [CW-1:0]  first_y;
    logic signed [CW-1:0]  second_x;
    logic signed [CW-1:0]  second_y;
    logic                  done;
    logic [BEARING_W-1:0]  bearing;

    logic [BEARING_W-1:0]  bearing_due [$];
    int                    mismatches = 0;

    // corners, flat lines, near-wrap angles and all four quadrants
    probe_t probes [N_DIRECTED] = '{
        '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, HALF_TURN},
        '{-16'sd5,     16'sd7,      16'sd10,     16'sd7,      1'b1, ZERO_TURN},
        '{16'sd10,     16'sd7,      -16'sd5,     16'sd7,      1'b1, HALF_TURN},
        '{16'sh8000,   16'sh7fff,   16'sh7fff,   16'sh7fff,   1'b1, ZERO_TURN},
        '{16'sh7fff,   16'sh8000,   16'sh8000,   16'sh8000,   1'b1, HALF_TURN},
        '{16'sh7fff,   16'sh7fff,   16'sh7fff,   16'sh7fff,   1'b1, HALF_TURN},
        '{16'sh8000,   16'sh8000,   16'sh8000,   16'sh8000,   1'b1, HALF_TURN},
        '{16'sd0,      16'sh7fff,   16'sd0,      16'sh8000,   1'b0, ZERO_TURN},
        '{16'sd0,      16'sh8000,   16'sd0,      16'sh7fff,   1'b0, ZERO_TURN},
        '{16'sd100,    16'sd100,    16'sd0,      16'sd0,      1'b0, ZERO_TURN},
        '{-16'sd100,   16'sd100,    16'sd0,      16'sd0,      1'b0, ZERO_TURN},
        '{-16'sd100,   -16'sd100,   16'sd0,      16'sd0,      1'b0, ZERO_TURN},
        '{16'sd100,    -16'sd100,   16'sd0,      16'sd0,      1'b0, ZERO_TURN},
        '{16'sh8000,   -16'sd1,     16'sh7fff,   16'sd0,      1'b0, ZERO_TURN},
        '{16'sh8000,   16'sd1,      16'sh7fff,   16'sd0,      1'b0, ZERO_TURN},
        '{16'sh7fff,   16'sd1,      16'sh8000,   16'sd0,      1'b0, ZERO_TURN},
        '{16'sh7fff,   -16'sd1,     16'sh8000,   16'sd0,      1'b0, ZERO_TURN},
        '{16'sh8000,   16'sh8000,   16'sh7fff,   16'sh7fff,   1'b0, ZERO_TURN},
        '{16'sh7fff,   16'sh7fff,   16'sh8000,   16'sh8000,   1'b0, ZERO_TURN},
        '{16'sd1,      16'sd0,      16'sd0,      16'sd1,      1'b0, ZERO_TURN},
        '{16'sd0,      16'sd0,      16'sd1,      -16'sd1,     1'b0, ZERO_TURN}
    };

    bearing_between_points #(
        .ITERATIONS  (N_STEPS),
        .COORD_WIDTH (CW)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .done     (done),
        .bearing  (bearing)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // atan(2^-k) in 2^-14 degree units
    function automatic longint atan_step(input int k);
        case (k)
            0:       return 737280;
            1:       return 435242;
            2:       return 229970;
            3:       return 116736;
            4:       return 58595;
            5:       return 29326;
            6:       return 14667;
            7:       return 7334;
            8:       return 3667;
            9:       return 1833;
            10:      return 917;
            11:      return 458;
            12:      return 229;
            13:      return 115;
            14:      return 57;
            15:      return 29;
            16:      return 14;
            17:      return 7;
            18:      return 4;
            19:      return 2;
            20:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [BEARING_W-1:0] predict_bearing(
        input logic signed [CW-1:0] fx,
        input logic signed [CW-1:0] fy,
        input logic signed [CW-1:0] sx,
        input logic signed [CW-1:0] sy
    );
        longint dx;
        longint px;
        longint py;
        longint px_sh;
        longint py_sh;
        longint base;
        longint acc;
        longint total;
        longint rounded;
        dx = longint'(fx) - longint'(sx);
        py = longint'(fy) - longint'(sy);
        px = -dx;
        base = 0;
        acc = 0;
        if (py == 0)
        begin
            return (dx < 0) ? ZERO_TURN : HALF_TURN;
        end
        // fold the left half-plane over to the right
        if (px < 0)
        begin
            px = -px;
            py = -py;
            base = longint'(DEG180);
        end
        px = px <<< SCALE_BITS;
        py = py <<< SCALE_BITS;
        for (int k = 0; k < N_STEPS && k < TABLE_LEN; k++)
        begin
            px_sh = px >>> k;
            py_sh = py >>> k;
            if (py >= 0)
            begin
                px  = px + py_sh;
                py  = py - px_sh;
                acc = acc + atan_step(k);
            end
            else
            begin
                px  = px - py_sh;
                py  = py + px_sh;
                acc = acc - atan_step(k);
            end
        end
        total = base + acc;
        if (total < 0)
            total = total + longint'(DEG360);
        rounded = (total + longint'(ROUND_HALF)) >>> FRAC_EXTRA;
        if (rounded >= longint'(FULL_TURN))
            rounded = rounded - longint'(FULL_TURN);
        return rounded[BEARING_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // issue one transaction, idling first with the given odds per cycle
    task automatic send_pair(
        input logic signed [CW-1:0] fx,
        input logic signed [CW-1:0] fy,
        input logic signed [CW-1:0] sx,
        input logic signed [CW-1:0] sy,
        input logic                 known,
        input logic [BEARING_W-1:0] want,
        input int                   idle_pct
    );
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        first_x  <= fx;
        first_y  <= fy;
        second_x <= sx;
        second_y <= sy;
        do
            @(posedge clk);
        while (busy);
        bearing_due.push_back(known ? want : predict_bearing(fx, fy, sx, sy));
    endtask

    function automatic logic signed [CW-1:0] pick_corner();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (bearing_due.size() == 0)
                note_mismatch("unexpected bearing, none pending", -1, int'(bearing));
            else if (bearing !== bearing_due[0])
            begin
                note_mismatch("bearing", int'(bearing_due[0]), int'(bearing));
                void'(bearing_due.pop_front());
            end
            else
                void'(bearing_due.pop_front());
        end
    end

    initial
    begin
        #4_000_000;
        $display("bearing_between_points test failed");
        $finish;
    end

    initial
    begin
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        int                   idle_pct;
        rst_n    = 1'b0;
        start    = 1'b0;
        first_x  = '0;
        first_y  = '0;
        second_x = '0;
        second_y = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[n])
            send_pair(probes[n].fx, probes[n].fy, probes[n].sx, probes[n].sy,
                      probes[n].known, probes[n].want, (n % 3 == 0) ? 50 : 0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // four phases: back to back, sparse, back to back, light gaps
            case ((n * 4) / N_RANDOM)
                0:       idle_pct = 0;
                1:       idle_pct = 76;
                2:       idle_pct = 0;
                default: idle_pct = 15;
            endcase
            fx = CW'($urandom);
            fy = CW'($urandom);
            sx = CW'($urandom);
            sy = CW'($urandom);
            case ($urandom_range(7))
                0:
                begin
                    sy = fy;
                end
                1:
                begin
                    sx = fx;
                    sy = fy;
                end
                2:
                begin
                    sx = fx + CW'($signed($urandom_range(16)) - 8);
                    sy = fy + CW'($signed($urandom_range(16)) - 8);
                end
                3:
                begin
                    fx = pick_corner();
                    fy = pick_corner();
                    sx = pick_corner();
                    sy = pick_corner();
                end
                4:
                begin
                    // shallow angle near the horizontal, both directions
                    sy = fy + CW'($signed($urandom_range(6)) - 3);
                end
                5:
                begin
                    sx = fx + CW'($signed($urandom_range(6)) - 3);
                end
                default:
                begin
                end
            endcase
            send_pair(fx, fy, sx, sy, 1'b0, ZERO_TURN, idle_pct);
        end
        start <= 1'b0;

        while (bearing_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        if (mismatches == 0)
            $display("bearing_between_points test passed");
        else
            $display("bearing_between_points test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bbp_pkg.sv
rtl/bbp_prep.sv
rtl/bbp_cordic_stage.sv
rtl/bbp_finish.sv
rtl/bearing_between_points.sv
dv/tb_bearing_between_points.sv
